// ===== hw/rtl/ltfs_pkg.sv =====
// Shared constants, types and codes of the lift target floor selector.
package ltfs_pkg;

    // Floor indexing and door map geometry.
    localparam int MAX_FLOORS  = 64;
    localparam int FLOOR_W     = 6;
    localparam int MAP_W       = 64;
    localparam int PROV_W      = 8;
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = MAP_W / GROUP_SIZE;
    localparam int IDX_W       = $clog2(GROUP_SIZE);
    localparam int GRP_W       = $clog2(NUM_GROUPS);

    // Direction codes.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_FLOOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_FLOOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOOR_MAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_FITTED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_FITTED = 3'd4;

    // Configuration register set.
    typedef struct packed {
        logic [FLOOR_W-1:0] highest_floor;
        logic [FLOOR_W-1:0] bottom_floor;
        logic [MAP_W-1:0]   door_floor_map;
        logic               lower_limit_fitted;
        logic               upper_limit_fitted;
    } cfg_t;

    // Load enables of the two door search stages.
    typedef struct packed {
        logic group_load;
        logic select_load;
    } search_en_t;

endpackage

// ===== hw/rtl/lift_target_floor_select_unit.sv =====
// Top level of the lift target floor selector: handshake, pipeline and configuration.
//
// The input channel (s_valid/s_ready) carries one item per lift trip request: the
// car level or an unknown-level flag, the requested direction, and the terminal
// limit and slowdown switch states. The result channel (m_valid/m_ready) returns
// exactly one item per input item, holding the target floor and start direction.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// top and bottom floors, the door floor map and the limit switch fitted flags; it
// is always ready and must be written only while no item is in flight.
// The datapath is a seven-stage pipeline: two stages reduce the car level modulo
// the top floor plus one, one runs the limit and slowdown decision tree, two search
// the door map (per-group priority, then group selection) and two reduce the result
// modulo the top floor plus one again. m_valid rises when an item reaches stage 7; an
// item may enter every cycle s_ready is high; the modulo stages with three remainder
// steps each set the stage depth. Reset clears all stage valid bits and loads the
// configuration reset values. When the receiver stalls, each stage holds while the
// one after it is full, so the pipeline fills up and s_ready drops with nothing lost.
module lift_target_floor_select_unit
    import ltfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FLOOR_W-1:0]   s_car_level,
    input  logic                 s_level_unknown,
    input  logic [1:0]           s_request_dir,
    input  logic                 s_at_lower_limit,
    input  logic                 s_at_upper_limit,
    input  logic                 s_in_lower_slowdown,
    input  logic                 s_in_upper_slowdown,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FLOOR_W-1:0]   m_goal_floor,
    output logic [1:0]           m_start_dir,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAP_W-1:0]     cfg_data
);

    localparam int NUM_STAGES = 7;

    cfg_t                  cfg_reg;
    logic [FLOOR_W:0]      span;
    logic [NUM_STAGES-1:0] stage_valid_reg;
    logic [NUM_STAGES:0]   stage_ready;
    search_en_t            search_en;

    // Stage 1: first half of the level remainder.
    logic [FLOOR_W-1:0] s1_rem_reg;
    logic [2:0]         s1_low_reg;
    logic               s1_unknown_reg;
    logic [1:0]         s1_req_reg;
    logic [3:0]         s1_sw_reg;
    // Stage 2: reduced level.
    logic [FLOOR_W-1:0] s2_level_reg;
    logic               s2_unknown_reg;
    logic [1:0]         s2_req_reg;
    logic [3:0]         s2_sw_reg;
    // Stage 3: provisional target and direction.
    logic [PROV_W-1:0]  s3_tgt_next;
    logic [1:0]         s3_dir_next;
    logic [PROV_W-1:0]  s3_tgt_reg;
    logic [1:0]         s3_dir_reg;
    // Stages 4 and 5: direction alongside the door search.
    logic [1:0]         s4_dir_reg;
    logic [1:0]         s5_dir_reg;
    logic [FLOOR_W-1:0] s5_floor;
    // Stages 6 and 7: result remainder.
    logic [FLOOR_W-1:0] s6_rem_reg;
    logic [2:0]         s6_low_reg;
    logic [1:0]         s6_dir_reg;
    logic [FLOOR_W-1:0] s7_tgt_reg;
    logic [1:0]         s7_dir_reg;

    // Three restoring remainder steps; r stays below span throughout.
    function automatic logic [FLOOR_W-1:0] rem_steps(
        input logic [FLOOR_W-1:0] r_in,
        input logic [2:0]         bits,
        input logic [FLOOR_W:0]   span_in
    );
        logic [FLOOR_W:0]   t;
        logic [FLOOR_W-1:0] r;
        r = r_in;
        for (int i = 2; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= span_in) begin
                t = t - span_in;
            end
            r = t[FLOOR_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.highest_floor      <= '1;
            cfg_reg.bottom_floor       <= '0;
            cfg_reg.door_floor_map     <= '1;
            cfg_reg.lower_limit_fitted <= 1'b1;
            cfg_reg.upper_limit_fitted <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TOP_FLOOR:    cfg_reg.highest_floor <= cfg_data[FLOOR_W-1:0];
                CFG_BOTTOM_FLOOR: cfg_reg.bottom_floor <= cfg_data[FLOOR_W-1:0];
                CFG_DOOR_MAP:     cfg_reg.door_floor_map <= cfg_data;
                CFG_LOWER_FITTED: cfg_reg.lower_limit_fitted <= cfg_data[0];
                CFG_UPPER_FITTED: cfg_reg.upper_limit_fitted <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign span = {1'b0, cfg_reg.highest_floor} + 1'b1;

    // Pipeline flow control: a stage loads when it is empty or its successor loads.
    always_comb begin
        stage_ready[NUM_STAGES] = m_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !stage_valid_reg[k] || stage_ready[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                stage_valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_ready[k]) begin
                    stage_valid_reg[k] <= stage_valid_reg[k-1];
                end
            end
        end
    end

    assign s_ready = stage_ready[0];
    assign m_valid = stage_valid_reg[NUM_STAGES-1];

    // Stages 1 and 2: car level modulo the top floor plus one.
    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            s1_rem_reg     <= rem_steps('0, s_car_level[5:3], span);
            s1_low_reg     <= s_car_level[2:0];
            s1_unknown_reg <= s_level_unknown;
            s1_req_reg     <= s_request_dir;
            s1_sw_reg      <= {s_at_lower_limit, s_at_upper_limit,
                               s_in_lower_slowdown, s_in_upper_slowdown};
        end
        if (stage_ready[1]) begin
            s2_level_reg   <= rem_steps(s1_rem_reg, s1_low_reg, span);
            s2_unknown_reg <= s1_unknown_reg;
            s2_req_reg     <= s1_req_reg;
            s2_sw_reg      <= s1_sw_reg;
        end
    end

    // Stage 3: decision tree over limit and slowdown switches.
    always_comb begin
        logic [PROV_W-1:0] lvl8;
        logic [PROV_W-1:0] bot8;
        logic [PROV_W-1:0] top8;
        logic              in_band;
        logic              above_bot;
        logic              lo_lim;
        logic              up_lim;
        logic              lo_sd;
        logic              up_sd;
        lvl8 = {{(PROV_W-FLOOR_W){1'b0}}, s2_level_reg};
        bot8 = {{(PROV_W-FLOOR_W){1'b0}}, cfg_reg.bottom_floor};
        top8 = {{(PROV_W-FLOOR_W){1'b0}}, cfg_reg.highest_floor};
        in_band   = (s2_level_reg >= cfg_reg.bottom_floor);
        above_bot = (s2_level_reg > cfg_reg.bottom_floor);
        {lo_lim, up_lim, lo_sd, up_sd} = s2_sw_reg;
        s3_tgt_next = lvl8;
        s3_dir_next = s2_req_reg;
        if (!s2_unknown_reg) begin
            if (lo_lim) begin
                s3_tgt_next = in_band ? lvl8 : bot8;
                s3_dir_next = DIR_UP;
            end else if (up_lim) begin
                s3_tgt_next = in_band ? lvl8 : top8;
                s3_dir_next = DIR_DOWN;
            end else if (lo_sd) begin
                if (!cfg_reg.lower_limit_fitted) begin
                    s3_tgt_next = in_band ? lvl8 + 1'b1 : bot8 + 1'b1;
                end else begin
                    s3_tgt_next = in_band ? lvl8 : bot8;
                end
            end else if (up_sd) begin
                if (!cfg_reg.upper_limit_fitted) begin
                    s3_tgt_next = above_bot ? lvl8 - 1'b1 : top8 - 1'b1;
                end else begin
                    s3_tgt_next = above_bot ? lvl8 : top8;
                end
            end
        end else begin
            if (lo_sd) begin
                if (!cfg_reg.lower_limit_fitted || lo_lim) begin
                    s3_tgt_next = bot8 + 1'b1;
                    s3_dir_next = DIR_UP;
                end else begin
                    s3_tgt_next = bot8;
                    s3_dir_next = DIR_DOWN;
                end
            end else if (up_sd) begin
                if (!cfg_reg.upper_limit_fitted || up_lim) begin
                    s3_tgt_next = top8 - 1'b1;
                    s3_dir_next = DIR_DOWN;
                end else begin
                    s3_tgt_next = top8;
                    s3_dir_next = DIR_UP;
                end
            end else begin
                s3_tgt_next = top8;
                s3_dir_next = DIR_UP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            s3_tgt_reg <= s3_tgt_next;
            s3_dir_reg <= s3_dir_next;
        end
    end

    // Stages 4 and 5: nearest door floor search.
    assign search_en.group_load  = stage_ready[3];
    assign search_en.select_load = stage_ready[4];

    ltfs_door_search u_door_search (
        .aclk      (aclk),
        .en        (search_en),
        .cfg       (cfg_reg),
        .tgt_in    (s3_tgt_reg),
        .dir_in    (s3_dir_reg),
        .floor_out (s5_floor)
    );

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            s4_dir_reg <= s3_dir_reg;
        end
        if (stage_ready[4]) begin
            s5_dir_reg <= s4_dir_reg;
        end
    end

    // Stages 6 and 7: result modulo the top floor plus one; stage 7 is the output register.
    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            s6_rem_reg <= rem_steps('0, s5_floor[5:3], span);
            s6_low_reg <= s5_floor[2:0];
            s6_dir_reg <= s5_dir_reg;
        end
        if (stage_ready[6]) begin
            s7_tgt_reg <= rem_steps(s6_rem_reg, s6_low_reg, span);
            s7_dir_reg <= s6_dir_reg;
        end
    end

    assign m_goal_floor = s7_tgt_reg;
    assign m_start_dir  = s7_dir_reg;

    // The reduced level never exceeds the top floor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg[1] |-> s2_level_reg <= cfg_reg.highest_floor)
        else $error("reduced level above top floor");

    // A delivered target floor never exceeds the top floor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_goal_floor <= cfg_reg.highest_floor)
        else $error("target floor above top floor");

    // The input side only stalls when every stage is full and the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&stage_valid_reg) && !m_ready)
        else $error("input stalled with room in the pipeline");

    // A stalled result keeps its valid bit into the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg[NUM_STAGES-1] && !m_ready |=> stage_valid_reg[NUM_STAGES-1])
        else $error("stalled result dropped");

endmodule

// ===== hw/rtl/ltfs_door_search.sv =====
// Two-stage search for the nearest floor with a shaft door, up or down.
module ltfs_door_search
    import ltfs_pkg::*;
(
    input  logic               aclk,
    input  search_en_t         en,
    input  cfg_t               cfg,
    input  logic [PROV_W-1:0]  tgt_in,
    input  logic [1:0]         dir_in,
    output logic [FLOOR_W-1:0] floor_out
);

    logic [MAP_W-1:0]     cand_mask;
    logic [NUM_GROUPS-1:0] grp_hit_next;
    logic [IDX_W-1:0]     grp_idx_next [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] grp_hit_reg;
    logic [IDX_W-1:0]     grp_idx_reg [NUM_GROUPS];
    logic                 up_next;
    logic                 up_reg;
    logic [FLOOR_W-1:0]   fallback_next;
    logic [FLOOR_W-1:0]   fallback_reg;
    logic [FLOOR_W-1:0]   floor_next;
    logic [FLOOR_W-1:0]   floor_reg;

    // Candidate floors: door present and inside the search window.
    always_comb begin
        logic [PROV_W-1:0] f8;
        up_next = (dir_in == DIR_UP);
        fallback_next = up_next ? cfg.highest_floor : cfg.bottom_floor;
        for (int f = 0; f < MAP_W; f++) begin
            f8 = PROV_W'(f);
            if (up_next) begin
                cand_mask[f] = cfg.door_floor_map[f] && (f < MAX_FLOORS) &&
                               (f8 >= tgt_in) &&
                               (f8 <= {{(PROV_W-FLOOR_W){1'b0}}, cfg.highest_floor});
            end else begin
                cand_mask[f] = cfg.door_floor_map[f] && (f < MAX_FLOORS) &&
                               (f8 <= tgt_in) &&
                               (f8 >= {{(PROV_W-FLOOR_W){1'b0}}, cfg.bottom_floor});
            end
        end
    end

    // Per-group priority: lowest hit going up, highest hit going down.
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_hit_next[g] = |cand_mask[g*GROUP_SIZE +: GROUP_SIZE];
            grp_idx_next[g] = '0;
            if (up_next) begin
                for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
                    if (cand_mask[g*GROUP_SIZE + b]) begin
                        grp_idx_next[g] = IDX_W'(b);
                    end
                end
            end else begin
                for (int b = 0; b < GROUP_SIZE; b++) begin
                    if (cand_mask[g*GROUP_SIZE + b]) begin
                        grp_idx_next[g] = IDX_W'(b);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.group_load) begin
            grp_hit_reg  <= grp_hit_next;
            grp_idx_reg  <= grp_idx_next;
            up_reg       <= up_next;
            fallback_reg <= fallback_next;
        end
    end

    // Group selection, falling back to the terminal floor when nothing hits.
    always_comb begin
        floor_next = fallback_reg;
        if (up_reg) begin
            for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
                if (grp_hit_reg[g]) begin
                    floor_next = {GRP_W'(g), grp_idx_reg[g]};
                end
            end
        end else begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                if (grp_hit_reg[g]) begin
                    floor_next = {GRP_W'(g), grp_idx_reg[g]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.select_load) begin
            floor_reg <= floor_next;
        end
    end

    assign floor_out = floor_reg;

endmodule
